>>> rtl/att_pkg.sv
// Package for the text terminal: geometry, byte codes, types and commands.
`default_nettype none
package att_pkg;
  localparam int COLS = 40;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int AW = 10;
  localparam int RW = 5;
  localparam int CW = 6;

  localparam logic [7:0] ESC_BYTE = 8'd27;
  localparam logic [7:0] NL_BYTE = 8'd10;
  localparam logic [7:0] HIGH_BIT = 8'h80;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UB = 8'h42;
  localparam logic [7:0] CH_UC = 8'h43;
  localparam logic [7:0] CH_UD = 8'h44;
  localparam logic [7:0] CH_UE = 8'h45;
  localparam logic [7:0] CH_UH = 8'h48;
  localparam logic [7:0] CH_UJ = 8'h4A;
  localparam logic [7:0] CH_UK = 8'h4B;
  localparam logic [7:0] CH_UM = 8'h4D;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_LM = 8'h6D;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_ESC = 2'd1;
  localparam logic [1:0] PH_CSI = 2'd2;
  localparam logic [1:0] PH_CHARSET = 2'd3;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_READ, S_CLEAR,
    S_SCR_RD, S_SCR_WR, S_SCR_TAIL, S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic decode;      // apply register updates of the byte
    logic rd_start;    // issue the read of the requested cell
    logic rd_take;     // capture the read data
    logic clr_start;   // prime the clear range
    logic clr_step;    // clear one cell
    logic scr_start;   // prime the scroll sweep
    logic scr_rd;      // read the cell one row below
    logic scr_wr;      // write it one row up
    logic tail_step;   // blank one cell of the last row
    logic out_load;    // load the result register
    logic init_step;   // reset clearing pass
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic need_clear;
    logic need_scroll;
    logic clr_done;
    logic scr_done;
    logic tail_done;
    logic init_done;
  } stat_t;
endpackage
`default_nettype wire

>>> rtl/att_if.sv
// Valid/ready channel interfaces for the terminal input and result items.
`default_nettype none
interface att_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic cmd;
  logic [7:0] ch;
  logic [9:0] cell_addr;
  modport source (output valid, cmd, ch, cell_addr, input ready);
  modport sink (input valid, cmd, ch, cell_addr, output ready);
endinterface

interface att_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [4:0] cursor_row;
  logic [5:0] cursor_col;
  logic [7:0] attribute;
  logic [1:0] escape_state;
  logic [7:0] cell_data;
  modport source (output valid, cursor_row, cursor_col, attribute, escape_state, cell_data,
                  input ready);
  modport sink (input valid, cursor_row, cursor_col, attribute, escape_state, cell_data,
                output ready);
endinterface
`default_nettype wire

>>> rtl/att_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/att_ctrl.sv
// Controller state machine of the text terminal.
`default_nettype none
module att_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire att_pkg::stat_t st,
  output att_pkg::cmd_t      cm
);
  import att_pkg::*;
  state_t state, state_next;
  logic out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: if (st.init_done) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (st.is_read) state_next = S_READ;
        else if (st.need_clear) state_next = S_CLEAR;
        else if (st.need_scroll) state_next = S_SCR_RD;
        else state_next = S_OUT;
      end
      S_READ: state_next = S_OUT;
      S_CLEAR: if (st.clr_done) state_next = S_OUT;
      S_SCR_RD: state_next = S_SCR_WR;
      S_SCR_WR: state_next = st.scr_done ? S_SCR_TAIL : S_SCR_RD;
      S_SCR_TAIL: if (st.tail_done) state_next = S_OUT;
      S_OUT: if (!out_full || out_ready) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
    // S_OUT waits only while the result register is still held.
    if (state == S_OUT && out_full && !out_ready) state_next = S_OUT;
  end

  always_comb begin
    cm = '0;
    in_ready = 1'b0;
    unique case (state)
      S_INIT: cm.init_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cm.load = in_valid;
      end
      S_DECODE: begin
        cm.decode = 1'b1;
        cm.rd_start = st.is_read;
        cm.clr_start = st.need_clear;
        cm.scr_start = st.need_scroll;
      end
      S_READ: cm.rd_take = 1'b1;
      S_CLEAR: cm.clr_step = 1'b1;
      S_SCR_RD: cm.scr_rd = 1'b1;
      S_SCR_WR: cm.scr_wr = 1'b1;
      S_SCR_TAIL: cm.tail_step = 1'b1;
      S_OUT: cm.out_load = !out_full || out_ready;
      default: ;
    endcase
  end

  assign out_valid = out_full;
endmodule
`default_nettype wire

>>> rtl/att_dp.sv
// Datapath of the text terminal: cursor, escape parser and screen store access.
`default_nettype none
module att_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_cmd,
  input  wire logic [7:0]    in_ch,
  input  wire logic [9:0]    in_addr,
  input  wire att_pkg::cmd_t cm,
  output att_pkg::stat_t     st,
  output logic [4:0]         o_row,
  output logic [5:0]         o_col,
  output logic [7:0]         o_attr,
  output logic [1:0]         o_esc,
  output logic [7:0]         o_data
);
  import att_pkg::*;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCR_END = AW'(CELLS - COLS);

  logic cmd_r;
  logic [7:0] ch_r;
  logic [AW-1:0] addr_r;
  logic [RW-1:0] row;
  logic [CW-1:0] column;
  logic [7:0] attr, first_param, second_param, saved_attr;
  logic [1:0] esc_phase, param_index;
  logic [RW-1:0] saved_row;
  logic [CW-1:0] saved_column;
  logic [7:0] rd_data;
  logic [AW-1:0] ptr, ptr_end;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0] ram_wdata, ram_rdata;

  att_ram #(.WIDTH(8), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Decode of the captured byte.
  logic [AW-1:0] line;
  logic [RW:0] row_sum;
  logic [CW:0] col_sum;
  logic [8:0] row_add;
  logic [8:0] col_add;
  logic [11:0] dig_val;
  logic is_digit;
  assign line = AW'(32'(row) * COLS);
  assign row_add = 9'(row) + 9'(first_param);
  assign col_add = 9'(column) + 9'(first_param);
  assign row_sum = (RW+1)'(row) + 1'b1;
  assign col_sum = (CW+1)'(column) + 1'b1;
  assign is_digit = ch_r >= CH_ZERO && ch_r <= CH_NINE;

  logic [AW-1:0] cur;
  assign cur = line + AW'(column);

  logic [RW-1:0] row_n;
  logic [CW-1:0] col_n;
  logic [7:0] attr_n, fp_n, sp_n;
  logic [1:0] esc_n, pi_n;
  logic clr_n, scr_n, wr_ch;
  logic [AW-1:0] cfrom, cto;

  always_comb begin
    logic [7:0] src;
    src = first_param;
    row_n = row; col_n = column; attr_n = attr; fp_n = first_param; sp_n = second_param;
    esc_n = esc_phase; pi_n = param_index; clr_n = 1'b0; scr_n = 1'b0; wr_ch = 1'b0;
    cfrom = '0; cto = '0;
    dig_val = '0;
    unique case (esc_phase)
      PH_ESC: begin
        esc_n = PH_NORMAL;
        case (ch_r)
          CH_LPAREN: esc_n = PH_CHARSET;
          CH_LBRACK: begin
            esc_n = PH_CSI; pi_n = '0; fp_n = '0; sp_n = '0;
          end
          CH_UD: if (row < LAST_ROW) row_n = row + 1'b1;
          CH_UM: if (row != '0) row_n = row - 1'b1;
          CH_UE: begin
            col_n = '0;
            if (row_sum >= (RW+1)'(ROWS)) scr_n = 1'b1;
            else row_n = row_sum[RW-1:0];
          end
          CH_SEVEN: ;
          CH_EIGHT: begin
            row_n = saved_row; col_n = saved_column; attr_n = saved_attr;
          end
          default: ;
        endcase
      end
      PH_CSI: begin
        if (is_digit) begin
          if (param_index == 2'd0) begin
            dig_val = 12'(first_param) * 12'd10 + 12'(ch_r - CH_ZERO);
            fp_n = dig_val[7:0];
          end else if (param_index == 2'd1) begin
            dig_val = 12'(second_param) * 12'd10 + 12'(ch_r - CH_ZERO);
            sp_n = dig_val[7:0];
          end else esc_n = PH_NORMAL;
        end else if (ch_r == CH_SEMI) begin
          if (param_index != 2'd3) pi_n = param_index + 1'b1;
        end else begin
          esc_n = PH_NORMAL;
          case (ch_r)
            CH_UA: row_n = (9'(src) >= 9'(row)) ? '0 : row - RW'(src);
            CH_UB: row_n = (row_add >= 9'(ROWS)) ? LAST_ROW : row_add[RW-1:0];
            CH_UC: col_n = (col_add >= 9'(COLS)) ? LAST_COL : col_add[CW-1:0];
            CH_UD: col_n = (9'(src) >= 9'(column)) ? '0 : column - CW'(src);
            CH_UH, CH_LF: begin
              row_n = (src < 8'(ROWS)) ? src[RW-1:0] : LAST_ROW;
              col_n = (second_param < 8'(COLS)) ? second_param[CW-1:0] : LAST_COL;
            end
            CH_LM: attr_n = src;
            CH_UK: begin
              clr_n = 1'b1;
              if (src == 8'd1) begin cfrom = line; cto = cur; end
              else if (src == 8'd2) begin cfrom = line; cto = line + AW'(COLS - 1); end
              else begin cfrom = cur; cto = line + AW'(COLS - 1); end
            end
            CH_UJ: begin
              clr_n = 1'b1;
              if (src == 8'd1) begin cfrom = '0; cto = cur; end
              else if (src == 8'd2) begin cfrom = '0; cto = LAST_CELL; end
              else begin cfrom = cur; cto = LAST_CELL; end
            end
            default: ;
          endcase
        end
      end
      PH_CHARSET: esc_n = PH_NORMAL;
      default: begin
        if (ch_r == NL_BYTE) begin
          col_n = '0;
          if (row_sum >= (RW+1)'(ROWS)) scr_n = 1'b1;
          else row_n = row_sum[RW-1:0];
        end else if (ch_r == ESC_BYTE) esc_n = PH_ESC;
        else begin
          wr_ch = 1'b1;
          if (col_sum >= (CW+1)'(COLS)) begin
            col_n = '0;
            if (row_sum >= (RW+1)'(ROWS)) scr_n = 1'b1;
            else row_n = row_sum[RW-1:0];
          end else col_n = col_sum[CW-1:0];
        end
      end
    endcase
  end

  assign st.is_read = cmd_r;
  assign st.need_clear = !cmd_r && clr_n;
  assign st.need_scroll = !cmd_r && scr_n;
  assign st.clr_done = ptr == ptr_end;
  assign st.scr_done = ptr == SCR_END - 1'b1;
  assign st.tail_done = ptr == LAST_CELL;
  assign st.init_done = ptr == LAST_CELL;

  always_comb begin
    ram_we = 1'b0; ram_addr = ptr; ram_wdata = '0;
    if (cm.rd_start) ram_addr = addr_r;
    else if (cm.decode) begin
      ram_addr = cur;
      ram_we = !cmd_r && wr_ch;
      ram_wdata = ch_r | ((attr == 8'd7) ? HIGH_BIT : 8'h00);
    end else if (cm.scr_rd) ram_addr = ptr + AW'(COLS);
    else if (cm.scr_wr) begin ram_we = 1'b1; ram_wdata = ram_rdata; end
    else if (cm.clr_step || cm.tail_step || cm.init_step) ram_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0; column <= '0; attr <= '0; esc_phase <= PH_NORMAL; param_index <= '0;
      first_param <= '0; second_param <= '0;
      saved_row <= '0; saved_column <= '0; saved_attr <= '0;
      ptr <= '0; ptr_end <= '0;
    end else begin
      if (cm.init_step && ptr != LAST_CELL) ptr <= ptr + 1'b1;
      if (cm.decode && !cmd_r) begin
        row <= row_n; column <= col_n; attr <= attr_n; esc_phase <= esc_n;
        param_index <= pi_n; first_param <= fp_n; second_param <= sp_n;
        if (esc_phase == PH_ESC && ch_r == CH_SEVEN) begin
          saved_row <= row; saved_column <= column; saved_attr <= attr;
        end
      end
      if (cm.clr_start) begin ptr <= cfrom; ptr_end <= cto; end
      if (cm.clr_step && ptr != ptr_end) ptr <= ptr + 1'b1;
      if (cm.scr_start) ptr <= '0;
      if (cm.scr_wr) ptr <= ptr + 1'b1;
      if (cm.tail_step && ptr != LAST_CELL) ptr <= ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cm.load) begin cmd_r <= in_cmd; ch_r <= in_ch; addr_r <= in_addr; end
    if (cm.decode) rd_data <= '0;
    if (cm.rd_take) rd_data <= (addr_r < AW'(CELLS)) ? ram_rdata : 8'h00;
    if (cm.out_load) begin
      o_row <= row; o_col <= column; o_attr <= attr; o_esc <= esc_phase;
      o_data <= rd_data;
    end
  end
endmodule
`default_nettype wire

>>> rtl/ansi_text_terminal.sv
// Top level of the character-cell text terminal.
`default_nettype none
// A 40 by 25 character terminal with a subset of escape handling. Each input
// item either feeds one byte (cmd 0) or reads one screen cell (cmd 1), and gives
// exactly one result item with the cursor, attribute and parser phase after the
// item. After reset the block sweeps the 1000-cell screen store clear, one cell
// a cycle, before it takes its first item. A plain byte passes through accept,
// decode and result load before the next item is taken, and a read adds a step
// that takes the data, since the read of the screen store is registered. Line
// and screen clears add a step per cell cleared, and a scroll walks the single
// port of the screen store, reading and then writing each moved cell, then
// blanking each cell of the last row. A finished result waits in its output
// register while the next item is taken, and a result that is still held there
// stalls the following one.
module ansi_text_terminal (
  input wire logic clk,
  input wire logic rst,
  att_in_if.sink   in_ch,
  att_out_if.source out_ch
);
  import att_pkg::*;
  cmd_t cm;
  stat_t st;

  att_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .st(st), .cm(cm)
  );

  att_dp u_dp (
    .clk(clk), .rst(rst), .in_cmd(in_ch.cmd), .in_ch(in_ch.ch), .in_addr(in_ch.cell_addr),
    .cm(cm), .st(st), .o_row(out_ch.cursor_row), .o_col(out_ch.cursor_col),
    .o_attr(out_ch.attribute), .o_esc(out_ch.escape_state), .o_data(out_ch.cell_data)
  );
endmodule
`default_nettype wire

>>> verif/tb_ansi_text_terminal.sv
// Testbench for the text terminal: directed and random byte streams checked against a predictor.
`default_nettype none
module tb_ansi_text_terminal;
  timeunit 1ns;
  timeprecision 1ps;
  import att_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEM_TARGET = 700;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [5:0] cursor_col;
    logic [7:0] attribute;
    logic [1:0] escape_state;
    logic [7:0] cell_data;
  } term_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  att_in_if in_ch (.clk(clk));
  att_out_if out_ch (.clk(clk));

  ansi_text_terminal uut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The predictor's own copy of the terminal state.
  logic [7:0] scr_mirror [CELLS];
  int unsigned cur_row, cur_col, cur_attr, phase, pidx, par1, par2;
  int unsigned sv_row, sv_col, sv_attr;

  term_result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int out_wait = 0;
  int out_gap;
  bit stim_done = 1'b0;

  task automatic wipe_cells(input int unsigned from, input int unsigned upto);
    int unsigned k;
    if (upto > CELLS) upto = CELLS;
    for (k = from; k < upto; k++) scr_mirror[k] = 8'h00;
  endtask

  task automatic advance_line();
    int k;
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (k = 0; k < CELLS - COLS; k++) scr_mirror[k] = scr_mirror[k + COLS];
      for (k = CELLS - COLS; k < CELLS; k++) scr_mirror[k] = 8'h00;
      cur_row = ROWS - 1;
    end
  endtask

  task automatic apply_csi(input logic [7:0] c);
    int unsigned here, line;
    here = cur_row * COLS + cur_col;
    line = cur_row * COLS;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (pidx == 0) par1 = (par1 * 10 + (c - CH_ZERO)) & 8'hFF;
      else if (pidx == 1) par2 = (par2 * 10 + (c - CH_ZERO)) & 8'hFF;
      else phase = PH_NORMAL;
      return;
    end
    if (c == CH_SEMI) begin
      if (pidx < 3) pidx++;
      return;
    end
    case (c)
      CH_UA: cur_row = (par1 >= cur_row) ? 0 : cur_row - par1;
      CH_UB: cur_row = (cur_row + par1 >= ROWS) ? ROWS - 1 : cur_row + par1;
      CH_UC: cur_col = (cur_col + par1 >= COLS) ? COLS - 1 : cur_col + par1;
      CH_UD: cur_col = (par1 >= cur_col) ? 0 : cur_col - par1;
      CH_UH, CH_LF: begin
        cur_row = (par1 < ROWS) ? par1 : ROWS - 1;
        cur_col = (par2 < COLS) ? par2 : COLS - 1;
      end
      CH_LM: cur_attr = par1;
      CH_UK: begin
        if (par1 == 1) wipe_cells(line, here + 1);
        else if (par1 == 2) wipe_cells(line, line + COLS);
        else wipe_cells(here, line + COLS);
      end
      CH_UJ: begin
        if (par1 == 1) wipe_cells(0, here + 1);
        else if (par1 == 2) wipe_cells(0, CELLS);
        else wipe_cells(here, CELLS);
      end
      default: ;
    endcase
    phase = PH_NORMAL;
  endtask

  task automatic apply_esc(input logic [7:0] c);
    phase = PH_NORMAL;
    case (c)
      CH_LPAREN: phase = PH_CHARSET;
      CH_LBRACK: begin
        phase = PH_CSI;
        pidx = 0;
        par1 = 0;
        par2 = 0;
      end
      CH_UD: if (cur_row < ROWS - 1) cur_row++;
      CH_UM: if (cur_row > 0) cur_row--;
      CH_UE: advance_line();
      CH_SEVEN: begin
        sv_row = cur_row;
        sv_col = cur_col;
        sv_attr = cur_attr;
      end
      CH_EIGHT: begin
        cur_row = sv_row;
        cur_col = sv_col;
        cur_attr = sv_attr;
      end
      default: ;
    endcase
  endtask

  // Updates the mirror for one item and returns the result the block should give.
  task automatic predict_item(input logic cmd, input logic [7:0] c, input logic [9:0] addr,
                              output term_result_t r);
    int unsigned idx;
    logic [7:0] data;
    data = 8'h00;
    if (cmd == 1'b0) begin
      if (phase == PH_ESC) apply_esc(c);
      else if (phase == PH_CSI) apply_csi(c);
      else if (phase == PH_CHARSET) phase = PH_NORMAL;
      else if (c == NL_BYTE) advance_line();
      else if (c == ESC_BYTE) phase = PH_ESC;
      else begin
        idx = cur_row * COLS + cur_col;
        if (idx < CELLS) scr_mirror[idx] = c | ((cur_attr == 7) ? HIGH_BIT : 8'h00);
        cur_col++;
        if (cur_col >= COLS) advance_line();
      end
    end else if (addr < CELLS) begin
      data = scr_mirror[addr];
    end
    r.cursor_row = cur_row[4:0];
    r.cursor_col = cur_col[5:0];
    r.attribute = cur_attr[7:0];
    r.escape_state = phase[1:0];
    r.cell_data = data;
  endtask

  // Sends one item after a random gap and queues its expected result. With no
  // gap, valid stays high straight into the next item.
  task automatic send_item(input logic cmd, input logic [7:0] c, input logic [9:0] addr);
    term_result_t r;
    int gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.ch <= c;
    in_ch.cell_addr <= addr;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(cmd, c, addr, r);
    expected_results.push_back(r);
    items_sent++;
  endtask

  task automatic feed_byte(input logic [7:0] c);
    send_item(1'b0, c, 10'($urandom_range(0, 1023)));
  endtask

  task automatic read_cell(input int unsigned addr);
    send_item(1'b1, 8'($urandom_range(0, 255)), addr[9:0]);
  endtask

  // Drops valid after the last accepted item and waits for every result.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Sends ESC [ p1 ; p2 final, with the parameters written in decimal.
  task automatic send_csi(input int p1, input int p2, input logic [7:0] fin);
    string digits;
    feed_byte(ESC_BYTE);
    feed_byte(CH_LBRACK);
    if (p1 >= 0) begin
      digits = $sformatf("%0d", p1);
      foreach (digits[i]) feed_byte(digits[i]);
    end
    if (p2 >= 0) begin
      feed_byte(CH_SEMI);
      digits = $sformatf("%0d", p2);
      foreach (digits[i]) feed_byte(digits[i]);
    end
    feed_byte(fin);
  endtask

  // Result side: random stalls, then each result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_ch.cursor_row);
          errors++;
        end else begin
          term_result_t e;
          e = expected_results.pop_front();
          if (e.cursor_row !== out_ch.cursor_row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $time, e.cursor_row,
                     out_ch.cursor_row);
            errors++;
          end
          if (e.cursor_col !== out_ch.cursor_col) begin
            $display("%0t: cursor_col expected %0d actual %0d", $time, e.cursor_col,
                     out_ch.cursor_col);
            errors++;
          end
          if (e.attribute !== out_ch.attribute) begin
            $display("%0t: attribute expected %0d actual %0d", $time, e.attribute,
                     out_ch.attribute);
            errors++;
          end
          if (e.escape_state !== out_ch.escape_state) begin
            $display("%0t: escape_state expected %0d actual %0d", $time, e.escape_state,
                     out_ch.escape_state);
            errors++;
          end
          if (e.cell_data !== out_ch.cell_data) begin
            $display("%0t: cell_data expected %0d actual %0d", $time, e.cell_data,
                     out_ch.cell_data);
            errors++;
          end
        end
      end
      // A fresh random stall length is drawn after each accepted result.
      if (out_ch.valid && out_ch.ready) begin
        out_gap = $urandom_range(0, 8);
        out_wait <= out_gap;
        out_ch.ready <= (out_gap == 0);
      end else if (!out_ch.ready) begin
        if (out_wait <= 1) out_ch.ready <= 1'b1;
        if (out_wait > 0) out_wait <= out_wait - 1;
      end
    end
  end

  // The watchdog counts cycles in which no item moves on either channel. The reset
  // clearing pass and a full scroll fit well inside the limit.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_plain_text();
    feed_byte(8'h00);
    feed_byte(8'hFF);
    feed_byte(8'h41);
    feed_byte(8'h07);
    read_cell(0);
    read_cell(1);
    read_cell(1023);
    read_cell(CELLS);
  endtask

  task automatic test_escapes();
    feed_byte(ESC_BYTE); feed_byte(CH_UD);
    feed_byte(ESC_BYTE); feed_byte(CH_UM);
    feed_byte(ESC_BYTE); feed_byte(CH_UM);
    feed_byte(ESC_BYTE); feed_byte(CH_UE);
    feed_byte(ESC_BYTE); feed_byte(CH_SEVEN);
    feed_byte(ESC_BYTE); feed_byte(CH_LPAREN); feed_byte(8'h42);
    feed_byte(ESC_BYTE); feed_byte(8'h5A);
    feed_byte(ESC_BYTE); feed_byte(CH_EIGHT);
    feed_byte(NL_BYTE);
  endtask

  task automatic test_csi();
    send_csi(7, -1, CH_LM);
    feed_byte(8'h61);
    read_cell(cur_row * COLS + cur_col - 1);
    send_csi(0, -1, CH_LM);
    send_csi(99, 255, CH_UH);
    send_csi(300, -1, CH_UA);
    send_csi(3, -1, CH_UB);
    send_csi(255, -1, CH_UD);
    send_csi(5, -1, CH_UC);
    send_csi(10, 20, CH_LF);
    send_csi(1, -1, CH_UK);
    send_csi(2, -1, CH_UK);
    send_csi(-1, -1, CH_UK);
    // A digit for a third parameter abandons the sequence.
    feed_byte(ESC_BYTE); feed_byte(CH_LBRACK); feed_byte(CH_SEMI); feed_byte(CH_SEMI);
    feed_byte(CH_SEMI); feed_byte(CH_SEMI); feed_byte(8'h35);
    send_csi(1, 1, 8'h7A);
    send_csi(1, -1, CH_UJ);
    send_csi(-1, -1, CH_UJ);
    send_csi(2, -1, CH_UJ);
  endtask

  task automatic test_scroll();
    int k;
    send_csi(24, 38, CH_UH);
    for (k = 0; k < 4; k++) feed_byte(8'($urandom_range(32, 126)));
    feed_byte(NL_BYTE);
    feed_byte(ESC_BYTE); feed_byte(CH_UE);
    read_cell(CELLS - COLS - 1);
  endtask

  task automatic test_random();
    int pick;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        feed_byte(8'($urandom_range(32, 126)));
      end else if (pick < 50) begin
        read_cell($urandom_range(0, 1023));
      end else if (pick < 75) begin
        // Well-formed CSI with random parameters and finals.
        case ($urandom_range(0, 9))
          0: send_csi($urandom_range(0, 30), -1, CH_UA);
          1: send_csi($urandom_range(0, 30), -1, CH_UB);
          2: send_csi($urandom_range(0, 45), -1, CH_UC);
          3: send_csi($urandom_range(0, 45), -1, CH_UD);
          4: send_csi($urandom_range(0, 30), $urandom_range(0, 45), CH_UH);
          5: send_csi($urandom_range(0, 30), $urandom_range(0, 45), CH_LF);
          6: send_csi($urandom_range(0, 1) ? 7 : $urandom_range(0, 255), -1, CH_LM);
          7: send_csi($urandom_range(0, 3), -1, CH_UK);
          8: send_csi($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : 1, -1, CH_UJ);
          default: send_csi($urandom_range(0, 255), $urandom_range(0, 255),
                            8'($urandom_range(0, 255)));
        endcase
      end else if (pick < 85) begin
        feed_byte(ESC_BYTE);
        case ($urandom_range(0, 6))
          0: feed_byte(CH_UD);
          1: feed_byte(CH_UM);
          2: feed_byte(CH_UE);
          3: feed_byte(CH_SEVEN);
          4: feed_byte(CH_EIGHT);
          5: begin feed_byte(CH_LPAREN); feed_byte(8'($urandom_range(0, 255))); end
          default: feed_byte(8'($urandom_range(0, 255)));
        endcase
      end else if (pick < 90) begin
        // Newlines are kept rare since each scroll at the bottom is slow.
        feed_byte(NL_BYTE);
      end else begin
        feed_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.cmd <= 1'b0;
    in_ch.ch <= 8'h00;
    in_ch.cell_addr <= 10'd0;
    foreach (scr_mirror[i]) scr_mirror[i] = 8'h00;
    cur_row = 0; cur_col = 0; cur_attr = 0; phase = PH_NORMAL; pidx = 0;
    par1 = 0; par2 = 0; sv_row = 0; sv_col = 0; sv_attr = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_plain_text();
    test_escapes();
    test_csi();
    test_scroll();
    // The sender holds off here until every outstanding result has come.
    wait_drained();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
